// ===== design/cfb_pkg.sv =====
package cfb_pkg;

  // Frame delimiters and CRC-16/MODBUS constants
  localparam logic [7:0]  SOH_BYTE   = 8'h01;
  localparam logic [7:0]  EOT_BYTE   = 8'h04;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // Command codes
  localparam logic [3:0] CMD_ALLDAT = 4'd1;
  localparam logic [3:0] CMD_SYSSSL = 4'd2;
  localparam logic [3:0] CMD_SYSSTA = 4'd3;
  localparam logic [3:0] CMD_ENGDT1 = 4'd4;
  localparam logic [3:0] CMD_FLTHIS = 4'd5;
  localparam logic [3:0] CMD_STRCMD = 4'd6;
  localparam logic [3:0] CMD_PWRDMD = 4'd7;
  localparam logic [3:0] CMD_PSSWRD = 4'd8;

  localparam int TextBytes = 14;
  localparam int TextBits  = 8 * TextBytes;

  // Command texts, right-justified (first character in the highest used byte)
  localparam logic [TextBits-1:0] CMD_TEXT [8] = '{
    TextBits'("ALLDAT"),
    TextBits'("SYSSSL"),
    TextBits'("SYSSTA"),
    TextBits'("ENGDT1"),
    TextBits'("FLTHIS"),
    TextBits'("STRCMD="),
    TextBits'("PWRDMD="),
    TextBits'("PSSWRD=USR123P")
  };

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SOH,
    ST_LEN,
    ST_TEXT,
    ST_DIGIT,
    ST_CRCL,
    ST_CRCH,
    ST_EOT
  } state_e;

  // Length of the fixed text of a command; zero for unknown codes
  function automatic logic [3:0] text_len(input logic [3:0] cmd);
    logic [3:0] len;
    case (cmd)
      CMD_ALLDAT, CMD_SYSSSL, CMD_SYSSTA, CMD_ENGDT1, CMD_FLTHIS: len = 4'd6;
      CMD_STRCMD, CMD_PWRDMD: len = 4'd7;
      CMD_PSSWRD: len = 4'd14;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // Character idx of the text of a known command
  function automatic logic [7:0] text_char(input logic [3:0] cmd, input logic [3:0] idx);
    logic [2:0] sel;
    logic [3:0] bidx;
    sel  = 3'(cmd - 4'd1);
    bidx = 4'(text_len(cmd) - 4'd1 - idx);
    return CMD_TEXT[sel][{bidx, 3'b000} +: 8];
  endfunction

  // Commands that carry a decimal value after the text
  function automatic logic has_value(input logic [3:0] cmd);
    return (cmd == CMD_STRCMD) || (cmd == CMD_PWRDMD);
  endfunction

endpackage

// ===== design/crc16_command_frame_builder.sv =====
// Channel   Ports                              Handshake
// command   command_index_i, param_value_i     taken when start && !busy
// frame     frame_byte_o, last_byte_o          one word per cycle with strobe_o
//
// A frame is 5 to 19 words long. Each item begins with the decimal conversion,
// two value bits per cycle, then sends one frame word per cycle; the CRC
// advances one payload byte per cycle.
// Reset clears the sequencer to idle. The receiver cannot stall; busy stays
// high from acceptance through the EOT word.
module crc16_command_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command_index_i,
  input  logic [15:0] param_value_i,
  output logic        strobe_o,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o
);
  import cfb_pkg::*;

  state_e     state_q, state_d;
  logic [3:0] cmd_q, cmd_d;
  logic [3:0] idx_q, idx_d;
  logic [2:0] dcnt_q, dcnt_d;

  logic       accept;
  logic       bcd_shift;
  logic [3:0] digit;
  logic [2:0] ndig;
  logic       bcd_done;
  logic       crc_upd;
  logic [15:0] crc;
  logic [3:0] tlen;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign tlen   = text_len(cmd_q);

  cfb_bcd_conv u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .value_i (param_value_i),
    .shift_i (bcd_shift),
    .digit_o (digit),
    .ndig_o  (ndig),
    .done_o  (bcd_done)
  );

  cfb_crc u_crc (
    .clk_i  (clk_i),
    .init_i (accept),
    .upd_i  (crc_upd),
    .byte_i (frame_byte_o),
    .crc_o  (crc)
  );

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= '0;
      idx_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // Next state and outputs
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    dcnt_d       = dcnt_q;
    strobe_o     = 1'b0;
    frame_byte_o = '0;
    last_byte_o  = 1'b0;
    bcd_shift    = 1'b0;
    crc_upd      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d   = command_index_i;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          state_d = ST_SOH;
        end
      end
      ST_SOH: begin
        strobe_o     = 1'b1;
        frame_byte_o = SOH_BYTE;
        state_d      = ST_LEN;
      end
      ST_LEN: begin
        strobe_o     = 1'b1;
        frame_byte_o = {4'b0, tlen} + (has_value(cmd_q) ? {5'b0, ndig} : 8'd0);
        idx_d        = '0;
        state_d      = (tlen == 4'd0) ? ST_CRCL : ST_TEXT;
      end
      ST_TEXT: begin
        strobe_o     = 1'b1;
        frame_byte_o = text_char(cmd_q, idx_q);
        crc_upd      = 1'b1;
        idx_d        = idx_q + 4'd1;
        if (idx_q == tlen - 4'd1) begin
          if (has_value(cmd_q)) begin
            dcnt_d  = ndig;
            state_d = ST_DIGIT;
          end else begin
            state_d = ST_CRCL;
          end
        end
      end
      ST_DIGIT: begin
        strobe_o     = 1'b1;
        frame_byte_o = ASCII_ZERO | {4'b0, digit};
        crc_upd      = 1'b1;
        bcd_shift    = 1'b1;
        dcnt_d       = dcnt_q - 3'd1;
        if (dcnt_q == 3'd1) begin
          state_d = ST_CRCL;
        end
      end
      ST_CRCL: begin
        strobe_o     = 1'b1;
        frame_byte_o = crc[7:0];
        state_d      = ST_CRCH;
      end
      ST_CRCH: begin
        strobe_o     = 1'b1;
        frame_byte_o = crc[15:8];
        state_d      = ST_EOT;
      end
      ST_EOT: begin
        strobe_o     = 1'b1;
        frame_byte_o = EOT_BYTE;
        last_byte_o  = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/cfb_bcd_conv.sv =====
module cfb_bcd_conv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [15:0] value_i,
  input  logic        shift_i,
  output logic [3:0]  digit_o,
  output logic [2:0]  ndig_o,
  output logic        done_o
);
  import cfb_pkg::*;

  logic [15:0] bin_q;
  logic [19:0] bcd_q, bcd_d;
  logic [2:0]  cnt_q;
  logic        run_q;
  logic        done_q;
  logic [2:0]  ndig_q, ndig_d;
  logic [19:0] step1, step2;

  // One double-dabble step: add 3 to every digit above 4, then shift in a bit
  function automatic logic [19:0] dd_step(input logic [19:0] bcd, input logic b);
    logic [19:0] adj;
    for (int k = 0; k < 5; k++) begin
      adj[4*k +: 4] = (bcd[4*k +: 4] > 4'd4) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
    return {adj[18:0], b};
  endfunction

  // Two bits per cycle
  assign step1 = dd_step(bcd_q, bin_q[15]);
  assign step2 = dd_step(step1, bin_q[14]);

  // Digit count and left alignment so the leading digit sits on top
  always_comb begin
    if (step2[19:16] != 4'd0) begin
      ndig_d = 3'd5;
      bcd_d  = step2;
    end else if (step2[15:12] != 4'd0) begin
      ndig_d = 3'd4;
      bcd_d  = {step2[15:0], 4'b0};
    end else if (step2[11:8] != 4'd0) begin
      ndig_d = 3'd3;
      bcd_d  = {step2[11:0], 8'b0};
    end else if (step2[7:4] != 4'd0) begin
      ndig_d = 3'd2;
      bcd_d  = {step2[7:0], 12'b0};
    end else begin
      ndig_d = 3'd1;
      bcd_d  = {step2[3:0], 16'b0};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ndig_q <= 3'd1;
    end else if (load_i) begin
      cnt_q  <= '0;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
        ndig_q <= ndig_d;
      end
    end
  end

  // Shift registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (run_q) begin
      bin_q <= {bin_q[13:0], 2'b00};
      bcd_q <= (cnt_q == 3'd7) ? bcd_d : step2;
    end else if (shift_i) begin
      bcd_q <= {bcd_q[15:0], 4'b0};
    end
  end

  assign digit_o = bcd_q[19:16];
  assign ndig_o  = ndig_q;
  assign done_o  = done_q;

endmodule

// ===== design/cfb_crc.sv =====
module cfb_crc (
  input  logic        clk_i,
  input  logic        init_i,
  input  logic        upd_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import cfb_pkg::*;

  logic [15:0] crc_q;

  // Reflected CRC over one byte, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      crc_q <= CRC_INIT;
    end else if (upd_i) begin
      crc_q <= crc_byte(crc_q, byte_i);
    end
  end

  assign crc_o = crc_q;

endmodule

// ===== design/cfb_checker.sv =====
module cfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [3:0]  command_index_i,
  input logic [15:0] param_value_i,
  input logic        strobe_o,
  input logic [7:0]  frame_byte_o,
  input logic        last_byte_o
);
  import cfb_pkg::*;

  // Words only come out while an item is in progress
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy) else $error("strobe while not busy");

  // An accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // The final word is a strobed EOT
  a_last_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> (strobe_o && frame_byte_o == EOT_BYTE)) else $error("bad last word");

  // The block is free right after the final word
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |=> !busy) else $error("busy after last word");

  // A frame opens with SOH right after a quiet cycle
  a_first_soh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !$past(strobe_o) && busy && $past(busy)) |-> frame_byte_o == SOH_BYTE)
    else $error("frame does not open with SOH");

endmodule

bind crc16_command_frame_builder cfb_checker u_cfb_checker (.*);
